[rtl/dca_pkg.sv]
// Shared types, codes and constants of the door command arbiter.
package dca_pkg;

    localparam int TIME_W     = 32;
    localparam int ID_W       = 11;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic REG_FRAME_ID = 1'b0;
    localparam logic REG_TIMEOUT  = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Driver button command codes.
    localparam logic [3:0] DCMD_NONE        = 4'd0;
    localparam logic [3:0] DCMD_OPEN_LEFT   = 4'd1;
    localparam logic [3:0] DCMD_OPEN_RIGHT  = 4'd2;
    localparam logic [3:0] DCMD_OPEN_ALL    = 4'd3;
    localparam logic [3:0] DCMD_CLOSE_LEFT  = 4'd4;
    localparam logic [3:0] DCMD_CLOSE_RIGHT = 4'd5;
    localparam logic [3:0] DCMD_CLOSE_ALL   = 4'd6;
    localparam logic [3:0] DCMD_EVACUATE    = 4'd7;

    // Bus frame command bytes.
    localparam logic [7:0] FCODE_OPEN_LEFT   = 8'h01;
    localparam logic [7:0] FCODE_OPEN_RIGHT  = 8'h02;
    localparam logic [7:0] FCODE_OPEN_ALL    = 8'h03;
    localparam logic [7:0] FCODE_CLOSE_LEFT  = 8'h11;
    localparam logic [7:0] FCODE_CLOSE_RIGHT = 8'h12;
    localparam logic [7:0] FCODE_CLOSE_ALL   = 8'h13;

    localparam logic [7:0] CHECK_MASK     = 8'hFF;
    localparam logic [3:0] FRAME_DATA_LEN = 4'd2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_DRIVER,
        OP_FRAME,
        OP_SET_MODE
    } op_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_PARAM,
        ST_STATE,
        ST_CHECK,
        ST_DATA
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_OPEN,
        EV_CLOSE
    } event_t;

    typedef enum logic [1:0] {
        MODE_REGULAR,
        MODE_REDUCED,
        MODE_EMERG,
        MODE_DIAG
    } mode_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] now_ms;
        logic [3:0]        driver_cmd;
        logic [ID_W-1:0]   frame_ident;
        logic [3:0]        frame_len;
        logic [7:0]        frame_code;
        logic [7:0]        frame_check;
        logic [2:0]        new_mode;
        logic              left_is_open;
        logic              right_is_open;
    } item_t;

    typedef struct packed {
        mode_t             op_mode;
        event_t            pending_left;
        event_t            pending_right;
        logic [TIME_W-1:0] last_frame_time;
        logic              frame_timed_out;
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]      frame_id;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        status_t status;
        event_t  left_event;
        event_t  right_event;
        logic    timeout_flag;
        logic    timeout_fault;
        logic    check_fault;
        mode_t   mode_now;
    } result_t;

endpackage

[rtl/dca_step.sv]
// Combinational command decode and state update for one transaction.
module dca_step (
    input  dca_pkg::item_t   item,
    input  dca_pkg::state_t  cur,
    input  dca_pkg::cfg_t    cfg,
    output dca_pkg::state_t  nxt,
    output dca_pkg::result_t res
);
    import dca_pkg::*;

    logic [TIME_W-1:0] age;
    logic              age_over;
    logic [1:0]        q_side;   // bit 0 left, bit 1 right
    event_t            q_ev;

    assign age      = item.now_ms - cur.last_frame_time;
    assign age_over = age > {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.timeout_ms};

    always_comb begin
        nxt    = cur;
        q_side = 2'b00;
        q_ev   = EV_NONE;

        res.status        = ST_OK;
        res.left_event    = EV_NONE;
        res.right_event   = EV_NONE;
        res.timeout_fault = 1'b0;
        res.check_fault   = 1'b0;

        unique case (item.op)
            OP_TICK: begin
                // The age check is skipped until a frame has been stamped.
                if (cur.last_frame_time != '0 && age_over) begin
                    nxt.frame_timed_out = 1'b1;
                    res.timeout_fault   = 1'b1;
                end
                res.left_event    = cur.pending_left;
                res.right_event   = cur.pending_right;
                nxt.pending_left  = EV_NONE;
                nxt.pending_right = EV_NONE;
                if (cur.op_mode == MODE_EMERG) begin
                    if (!item.left_is_open) begin
                        nxt.pending_left = EV_OPEN;
                    end
                    if (!item.right_is_open) begin
                        nxt.pending_right = EV_OPEN;
                    end
                end
            end
            OP_DRIVER: begin
                if (item.driver_cmd[3]) begin
                    res.status = ST_PARAM;
                end else if (cur.op_mode == MODE_DIAG) begin
                    res.status = ST_STATE;
                end else begin
                    unique case (item.driver_cmd)
                        DCMD_OPEN_LEFT:   begin q_side = 2'b01; q_ev = EV_OPEN;  end
                        DCMD_OPEN_RIGHT:  begin q_side = 2'b10; q_ev = EV_OPEN;  end
                        DCMD_OPEN_ALL:    begin q_side = 2'b11; q_ev = EV_OPEN;  end
                        DCMD_CLOSE_LEFT:  begin q_side = 2'b01; q_ev = EV_CLOSE; end
                        DCMD_CLOSE_RIGHT: begin q_side = 2'b10; q_ev = EV_CLOSE; end
                        DCMD_CLOSE_ALL:   begin q_side = 2'b11; q_ev = EV_CLOSE; end
                        DCMD_EVACUATE: begin
                            nxt.op_mode = MODE_EMERG;
                            q_side      = 2'b11;
                            q_ev        = EV_OPEN;
                        end
                        default: begin
                            q_side = 2'b00;
                        end
                    endcase
                end
            end
            OP_FRAME: begin
                if (item.frame_ident != cfg.frame_id || item.frame_len != FRAME_DATA_LEN) begin
                    res.status = ST_PARAM;
                end else if (item.frame_check != (CHECK_MASK ^ item.frame_code)) begin
                    res.status      = ST_CHECK;
                    res.check_fault = 1'b1;
                end else begin
                    unique case (item.frame_code)
                        FCODE_OPEN_LEFT:   begin q_side = 2'b01; q_ev = EV_OPEN;  end
                        FCODE_OPEN_RIGHT:  begin q_side = 2'b10; q_ev = EV_OPEN;  end
                        FCODE_OPEN_ALL:    begin q_side = 2'b11; q_ev = EV_OPEN;  end
                        FCODE_CLOSE_LEFT:  begin q_side = 2'b01; q_ev = EV_CLOSE; end
                        FCODE_CLOSE_RIGHT: begin q_side = 2'b10; q_ev = EV_CLOSE; end
                        FCODE_CLOSE_ALL:   begin q_side = 2'b11; q_ev = EV_CLOSE; end
                        default: begin
                            res.status = ST_DATA;
                        end
                    endcase
                    if (res.status == ST_OK) begin
                        nxt.last_frame_time = item.now_ms;
                        nxt.frame_timed_out = 1'b0;
                    end
                end
            end
            OP_SET_MODE: begin
                if (item.new_mode[2]) begin
                    res.status = ST_PARAM;
                end else begin
                    nxt.op_mode = mode_t'(item.new_mode[1:0]);
                    if (mode_t'(item.new_mode[1:0]) == MODE_EMERG) begin
                        q_side = 2'b11;
                        q_ev   = EV_OPEN;
                    end
                end
            end
            default: begin
                res.status = ST_OK;
            end
        endcase

        if (q_side[0]) begin
            nxt.pending_left = q_ev;
        end
        if (q_side[1]) begin
            nxt.pending_right = q_ev;
        end

        res.timeout_flag = nxt.frame_timed_out;
        res.mode_now     = nxt.op_mode;
    end

endmodule

[rtl/door_command_arbiter.sv]
// Top level of the door command arbiter: input register, state, result register.
//
// The arbiter takes one transaction per clock cycle on the s_ channel while s_ready is
// high and returns exactly one result per transaction on the m_ channel, in order. A
// transaction is captured in an input register; in the cycle it moves on, the command
// decode and the state update are done in one pass of combinational logic and the result
// is written into the output register, from which it is presented on the m_ channel.
// Throughput is one transaction per cycle as long as m_ready is high; the only limit is
// the single output register, which holds a result until it is taken, and s_ready drops
// only when both the input and the output register are full and m_ready is low. Ticks
// dispatch and clear the pending door events, in emergency mode queue an open event for
// each door that is not open, and check the age of the last valid bus frame against the
// timeout register, with the age computed modulo 2^32 and skipped while no frame has been
// stamped. The two configuration registers (index 0 the command frame identifier, index 1
// the timeout in milliseconds) are written through cfg_wr_en with no wait state and must
// only be written while no transaction is in flight.
module door_command_arbiter (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [dca_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [dca_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [3:0]                        s_driver_cmd,
    input  logic [dca_pkg::ID_W-1:0]          s_frame_ident,
    input  logic [3:0]                        s_frame_len,
    input  logic [7:0]                        s_frame_code,
    input  logic [7:0]                        s_frame_check,
    input  logic [2:0]                        s_new_mode,
    input  logic                              s_left_is_open,
    input  logic                              s_right_is_open,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output logic [1:0]                        m_left_event,
    output logic [1:0]                        m_right_event,
    output logic                              m_timeout_flag,
    output logic                              m_timeout_fault,
    output logic                              m_check_fault,
    output logic [1:0]                        m_mode_now
);
    import dca_pkg::*;

    // Input register stage.
    logic    in_valid_reg;
    item_t   item_reg;
    item_t   item_next;

    // Block state and configuration.
    state_t  state_reg;
    state_t  state_next;
    cfg_t    cfg_reg;

    // Result register stage.
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic    advance;

    // The held transaction is processed when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        item_next.op            = op_t'(s_op);
        item_next.now_ms        = s_now_ms;
        item_next.driver_cmd    = s_driver_cmd;
        item_next.frame_ident   = s_frame_ident;
        item_next.frame_len     = s_frame_len;
        item_next.frame_code    = s_frame_code;
        item_next.frame_check   = s_frame_check;
        item_next.new_mode      = s_new_mode;
        item_next.left_is_open  = s_left_is_open;
        item_next.right_is_open = s_right_is_open;
    end

    dca_step u_step (
        .item (item_reg),
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_id   <= '0;
            cfg_reg.timeout_ms <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_ID: cfg_reg.frame_id   <= cfg_wr_data[ID_W-1:0];
                REG_TIMEOUT:  cfg_reg.timeout_ms <= cfg_wr_data[TIMEOUT_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Input register: valid is control, the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

    // State moves forward exactly once per processed transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.op_mode         <= MODE_REGULAR;
            state_reg.pending_left    <= EV_NONE;
            state_reg.pending_right   <= EV_NONE;
            state_reg.last_frame_time <= '0;
            state_reg.frame_timed_out <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register holds its transaction until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = result_reg.status;
    assign m_left_event    = result_reg.left_event;
    assign m_right_event   = result_reg.right_event;
    assign m_timeout_flag  = result_reg.timeout_flag;
    assign m_timeout_fault = result_reg.timeout_fault;
    assign m_check_fault   = result_reg.check_fault;
    assign m_mode_now      = result_reg.mode_now;

endmodule
